>>> src/afp_pkg.sv
package afp_pkg;

  localparam logic [7:0] HEADER_BYTE       = 8'h55;
  localparam logic [7:0] FRAME_TYPE_RESET  = 8'h53;
  // Position of the checksum byte within a frame (eleven bytes, counted from 0)
  localparam logic [3:0] CHECKSUM_POS      = 4'd10;
  localparam logic [3:0] TYPE_POS          = 4'd1;
  localparam logic [3:0] FIRST_DATA_POS    = 4'd2;
  localparam logic [3:0] YAW_LOW_POS       = 4'd6;
  localparam logic [3:0] YAW_HIGH_POS      = 4'd7;

  typedef enum logic [1:0] {
    PH_HUNT      = 2'd0,
    PH_WAIT_TYPE = 2'd1,
    PH_COLLECT   = 2'd2
  } phase_t;

  typedef struct packed {
    logic               hit;
    logic signed [15:0] yaw;
  } frame_result_t;

endpackage

>>> src/afp_frame_fsm.sv
module afp_frame_fsm (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic [7:0]             rx_byte,
  input  logic [7:0]             frame_type,
  output afp_pkg::frame_result_t result
);

  afp_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]      pos_r, pos_nxt;
  logic [7:0]      sum_r, sum_nxt;
  logic [7:0]      yaw_lo_r, yaw_lo_nxt;
  logic [7:0]      yaw_hi_r, yaw_hi_nxt;

  // Next state
  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    sum_nxt    = sum_r;
    yaw_lo_nxt = yaw_lo_r;
    yaw_hi_nxt = yaw_hi_r;
    if (step) begin
      case (phase_r)
        afp_pkg::PH_WAIT_TYPE: begin
          // Ignore stray bytes; keep waiting for the type byte
          if (rx_byte == frame_type) begin
            sum_nxt   = sum_r + rx_byte;
            pos_nxt   = afp_pkg::FIRST_DATA_POS;
            phase_nxt = afp_pkg::PH_COLLECT;
          end
        end
        afp_pkg::PH_COLLECT: begin
          if (pos_r >= afp_pkg::CHECKSUM_POS) begin
            phase_nxt = afp_pkg::PH_HUNT;
            pos_nxt   = 4'd0;
            sum_nxt   = 8'd0;
          end else begin
            if (pos_r == afp_pkg::YAW_LOW_POS) begin
              yaw_lo_nxt = rx_byte;
            end else if (pos_r == afp_pkg::YAW_HIGH_POS) begin
              yaw_hi_nxt = rx_byte;
            end
            sum_nxt = sum_r + rx_byte;
            pos_nxt = pos_r + 4'd1;
          end
        end
        default: begin
          // Hunting for the header
          if (rx_byte == afp_pkg::HEADER_BYTE) begin
            phase_nxt = afp_pkg::PH_WAIT_TYPE;
            pos_nxt   = afp_pkg::TYPE_POS;
            sum_nxt   = rx_byte;
          end else begin
            phase_nxt = afp_pkg::PH_HUNT;
            pos_nxt   = 4'd0;
            sum_nxt   = 8'd0;
          end
        end
      endcase
    end
  end

  // Outputs: hit flags a good checksum on the presented byte, whether or not
  // it is consumed this cycle
  always_comb begin
    result.yaw = $signed({yaw_hi_r, yaw_lo_r});
    case (phase_r)
      afp_pkg::PH_COLLECT:
        result.hit = (pos_r >= afp_pkg::CHECKSUM_POS) && (sum_r == rx_byte);
      default:
        result.hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= afp_pkg::PH_HUNT;
      pos_r    <= 4'd0;
      sum_r    <= 8'd0;
      yaw_lo_r <= 8'd0;
      yaw_hi_r <= 8'd0;
    end else begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      sum_r    <= sum_nxt;
      yaw_lo_r <= yaw_lo_nxt;
      yaw_hi_r <= yaw_hi_nxt;
    end
  end

  a_hit_rehunt: assert property (@(posedge clk) disable iff (!rst_n)
    (step && result.hit) |=>
      (phase_r == afp_pkg::PH_HUNT) && (pos_r == 4'd0) && (sum_r == 8'd0))
    else $error("parser did not return to hunting after a good frame");

  a_wait_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == afp_pkg::PH_WAIT_TYPE) |-> (pos_r == afp_pkg::TYPE_POS))
    else $error("byte position out of step while waiting for type");

  a_collect_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == afp_pkg::PH_COLLECT) |->
      (pos_r >= afp_pkg::FIRST_DATA_POS) && (pos_r <= afp_pkg::CHECKSUM_POS))
    else $error("byte position outside the frame while collecting");

endmodule

>>> src/angle_frame_parser_core.sv
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    in_rx_byte    [7:0]  unsigned
// out_      output     out_valid / out_ready  out_yaw_angle [15:0] signed
// cfg_      input      cfg_wr_en              cfg_wr_data   [7:0]  frame type
//
// One beat per cycle sustained unless the parser stalls: a byte lands in the
// input register and the frame parser consumes it from there, and a result
// is written to the output register when its checksum byte is consumed.
// The parser stalls only when a good frame completes while the output register
// still holds an untaken result; the input register then holds its byte and
// in_ready stays low until the output register has room.
// Reset (rst_n, synchronous) clears the parser to hunting, empties both
// registers and loads the frame type with 0x53.
module angle_frame_parser_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_yaw_angle,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data
);

  logic                  in_valid_r;
  logic [7:0]            in_byte_r;
  logic                  out_valid_r;
  logic signed [15:0]    out_yaw_r;
  logic [7:0]            frame_type_r;
  logic                  proc_en;
  logic                  out_room;
  logic                  out_wr;
  afp_pkg::frame_result_t result;

  // Room in the output register: empty, or its beat leaves this cycle
  assign out_room = !out_valid_r || out_ready;

  afp_frame_fsm u_fsm (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (proc_en),
    .rx_byte    (in_byte_r),
    .frame_type (frame_type_r),
    .result     (result)
  );

  // Advance the parser unless a finished frame would find the output full.
  // The hit does not depend on step, so the stall decision has no loop.
  assign proc_en  = in_valid_r && (out_room || !result.hit);
  assign out_wr   = proc_en && result.hit;
  assign in_ready = !in_valid_r || proc_en;

  assign out_valid     = out_valid_r;
  assign out_yaw_angle = out_yaw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      frame_type_r <= afp_pkg::FRAME_TYPE_RESET;
    end else begin
      if (cfg_wr_en) begin
        frame_type_r <= cfg_wr_data;
      end
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (out_wr) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
    if (out_wr) begin
      out_yaw_r <= result.yaw;
    end
  end

  a_hold_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !proc_en) |=> in_valid_r && $stable(in_byte_r))
    else $error("held input byte was lost or changed");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_wr |-> out_room)
    else $error("result written over an untaken beat");

  a_rose_from_hit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(out_wr))
    else $error("output beat appeared without a good frame");

endmodule
